[rtl/sldo_pkg.sv]
// shared types and constants of the sprite layer draw order unit
package sldo_pkg;

  // store geometry
  localparam int unsigned MaxSprites = 64;
  localparam int unsigned AddrW      = $clog2(MaxSprites);
  localparam int unsigned CntW       = $clog2(MaxSprites + 1);

  // field widths
  localparam int unsigned HandleW = 13;
  localparam int unsigned IdW     = 16;
  localparam int unsigned LayerW  = 2;
  localparam int unsigned ChrW    = 8;
  localparam int unsigned KeyW    = LayerW + ChrW;
  localparam int unsigned CfgIdxW = 8;

  // stream word widths
  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 16;

  // character ids run from 1 up to below this bound
  localparam int unsigned CharIdLimit = 256;

  // layer codes
  localparam logic [LayerW-1:0] LayerBg    = 2'd0;
  localparam logic [LayerW-1:0] LayerChar  = 2'd1;
  localparam logic [LayerW-1:0] LayerColl  = 2'd2;
  localparam logic [LayerW-1:0] LayerFront = 2'd3;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgBgId   = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgFrontId = 8'd1;
  localparam logic [CfgIdxW-1:0] CfgCollId = 8'd2;
  localparam logic [CfgIdxW-1:0] CfgCollEn = 8'd3;

  // register reset values
  localparam logic [IdW-1:0] BgIdRst    = 16'd0;
  localparam logic [IdW-1:0] FrontIdRst = 16'd256;
  localparam logic [IdW-1:0] CollIdRst  = 16'd257;

  // one stored entry
  typedef struct packed {
    logic [HandleW-1:0] handle;
    logic [LayerW-1:0]  layer;
    logic [ChrW-1:0]    chr;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  // read address source
  typedef enum logic [1:0] {
    RdCntLast,
    RdPtrPrev2,
    RdIdx
  } rd_src_e;

  // controller states
  typedef enum logic [2:0] {
    StIdle,
    StShift,
    StPlace,
    StEmitRd,
    StEmitOut
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic    capture;
    logic    rd_en;
    rd_src_e rd_src;
    logic    wr_en;
    logic    wr_shift;
    logic    ptr_dec;
    logic    cnt_inc;
    logic    idx_inc;
    logic    frame_clr;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic keep;
    logic full;
    logic cnt_zero;
    logic greater;
    logic ptr_one;
    logic idx_last;
    logic last_pend;
  } dp_status_t;

endpackage

[rtl/sldo_ram.sv]
// generic single write port memory with registered read
module sldo_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read, holds when idle
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[rtl/sldo_datapath.sv]
// datapath: registers, classification, ordered entry store and result fields
module sldo_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [sldo_pkg::HandleW-1:0]  in_handle_i,
  input  logic [sldo_pkg::IdW-1:0]      in_id_i,
  input  logic                          in_hidden_i,
  input  logic                          in_last_i,
  input  logic                          cfg_we_i,
  input  logic [sldo_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [sldo_pkg::IdW-1:0]      cfg_data_i,
  input  sldo_pkg::ctrl_cmd_t           cmd_i,
  output sldo_pkg::dp_status_t          status_o,
  output logic [sldo_pkg::HandleW-1:0]  out_handle_o,
  output logic [sldo_pkg::LayerW-1:0]   out_layer_o,
  output logic                          out_overflow_o
);
  import sldo_pkg::*;

  logic [IdW-1:0]   bg_id_q, front_id_q, coll_id_q;
  logic             coll_en_q;
  logic [CntW-1:0]  cnt_q, ptr_q;
  logic [AddrW-1:0] idx_q;
  entry_t           new_q;
  logic             last_q;
  logic             ovf_q;

  entry_t           in_entry;
  logic             is_char;
  logic             in_class;
  entry_t           rd_entry;
  logic [EntryW-1:0] rd_data;
  logic [CntW-1:0]  cnt_m1, ptr_m2;
  logic [AddrW-1:0] rd_addr;
  logic [KeyW-1:0]  rd_key, new_key;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bg_id_q    <= BgIdRst;
      front_id_q <= FrontIdRst;
      coll_id_q  <= CollIdRst;
      coll_en_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgBgId:    bg_id_q    <= cfg_data_i;
        CfgFrontId: front_id_q <= cfg_data_i;
        CfgCollId:  coll_id_q  <= cfg_data_i;
        CfgCollEn:  coll_en_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // classify the incoming word, first match wins
  assign is_char = (in_id_i[IdW-1:ChrW] == '0) && (in_id_i[ChrW-1:0] != '0);

  always_comb begin
    in_entry        = '0;
    in_entry.handle = in_handle_i;
    in_class        = 1'b1;
    if (in_id_i == bg_id_q) begin
      in_entry.layer = LayerBg;
    end else if (in_id_i == front_id_q) begin
      in_entry.layer = LayerFront;
    end else if (is_char) begin
      in_entry.layer = LayerChar;
      in_entry.chr   = in_id_i[ChrW-1:0];
    end else if (coll_en_q && (in_id_i == coll_id_q)) begin
      in_entry.layer = LayerColl;
    end else begin
      in_class = 1'b0;
    end
  end

  // read address selection
  assign cnt_m1 = cnt_q - CntW'(1);
  assign ptr_m2 = ptr_q - CntW'(2);

  always_comb begin
    case (cmd_i.rd_src)
      RdCntLast:  rd_addr = cnt_m1[AddrW-1:0];
      RdPtrPrev2: rd_addr = ptr_m2[AddrW-1:0];
      RdIdx:      rd_addr = idx_q;
      default:    rd_addr = idx_q;
    endcase
  end

  // ordered entry store
  sldo_ram #(
    .Width (EntryW),
    .Depth (MaxSprites)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (cmd_i.wr_en),
    .wr_addr_i (ptr_q[AddrW-1:0]),
    .wr_data_i (cmd_i.wr_shift ? rd_data : EntryW'(new_q)),
    .rd_en_i   (cmd_i.rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign rd_entry = entry_t'(rd_data);

  // sort keys: layer rank above character id
  assign rd_key  = {rd_entry.layer, rd_entry.chr};
  assign new_key = {new_q.layer, new_q.chr};

  // frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      ptr_q  <= '0;
      idx_q  <= '0;
      last_q <= 1'b0;
      ovf_q  <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        last_q <= in_last_i;
        ptr_q  <= cnt_q;
        if (!in_hidden_i && in_class && (cnt_q == CntW'(MaxSprites))) begin
          ovf_q <= 1'b1;
        end
      end
      if (cmd_i.ptr_dec) begin
        ptr_q <= ptr_q - CntW'(1);
      end
      if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + CntW'(1);
      end
      if (cmd_i.idx_inc) begin
        idx_q <= idx_q + AddrW'(1);
      end
      if (cmd_i.frame_clr) begin
        cnt_q  <= '0;
        idx_q  <= '0;
        ovf_q  <= 1'b0;
        last_q <= 1'b0;
      end
    end
  end

  // new entry payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      new_q <= in_entry;
    end
  end

  // status back to the controller
  assign status_o.keep      = !in_hidden_i && in_class;
  assign status_o.full      = (cnt_q == CntW'(MaxSprites));
  assign status_o.cnt_zero  = (cnt_q == '0);
  assign status_o.greater   = (rd_key > new_key);
  assign status_o.ptr_one   = (ptr_q == CntW'(1));
  assign status_o.idx_last  = (CntW'(idx_q) == cnt_m1);
  assign status_o.last_pend = last_q;

  // result fields
  assign out_handle_o   = rd_entry.handle;
  assign out_layer_o    = rd_entry.layer;
  assign out_overflow_o = ovf_q;

endmodule

[rtl/sldo_ctrl.sv]
// controller: sequences loading, insertion shifts and emission
module sldo_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 in_last_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 out_last_o,
  input  sldo_pkg::dp_status_t status_i,
  output sldo_pkg::ctrl_cmd_t  cmd_o
);
  import sldo_pkg::*;

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    cmd_o.rd_src = RdIdx;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    out_last_o  = status_i.idx_last;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          if (status_i.keep && !status_i.full) begin
            if (status_i.cnt_zero) begin
              state_d = StPlace;
            end else begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_src = RdCntLast;
              state_d      = StShift;
            end
          end else if (in_last_i) begin
            if (status_i.cnt_zero) begin
              cmd_o.frame_clr = 1'b1;
            end else begin
              state_d = StEmitRd;
            end
          end
        end
      end
      StShift: begin
        cmd_o.wr_en = 1'b1;
        if (status_i.greater) begin
          // move the larger entry up one slot
          cmd_o.wr_shift = 1'b1;
          cmd_o.ptr_dec  = 1'b1;
          if (status_i.ptr_one) begin
            state_d = StPlace;
          end else begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_src = RdPtrPrev2;
          end
        end else begin
          cmd_o.cnt_inc = 1'b1;
          state_d       = status_i.last_pend ? StEmitRd : StIdle;
        end
      end
      StPlace: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        state_d       = status_i.last_pend ? StEmitRd : StIdle;
      end
      StEmitRd: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_src = RdIdx;
        state_d      = StEmitOut;
      end
      StEmitOut: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (status_i.idx_last) begin
            cmd_o.frame_clr = 1'b1;
            state_d         = StIdle;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = StEmitRd;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

endmodule

[rtl/sprite_layer_draw_order_unit.sv]
// top level of the sprite layer draw order unit
//
// Takes sprite entries one word at a time and, on the word marked tlast,
// streams out the frame's draw order: background entries in arrival order,
// characters (ids 1..255) stably sorted by ascending id, collision entries
// when enabled, then front entries. Up to 64 entries are kept per frame;
// further ones are dropped and flagged on every result of that frame.
// Loading: a hidden, discarded or dropped word is accepted without an
// insertion; for a stored word the insertion shifts every stored entry with a
// larger sort key up one slot per cycle through the single write port of the
// entry memory, then writes the word. Each result word is emitted by a
// registered memory read, then the output handshake. A frame with no kept
// entries produces no results. The store needs no clearing after reset.
module sprite_layer_draw_order_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [sldo_pkg::InDataW-1:0]    s_axis_tdata,   // sprite_handle, sprite_id, zeros
  input  logic                            s_axis_tuser,   // hidden
  input  logic                            s_axis_tlast,
  // output stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [sldo_pkg::OutDataW-1:0]   m_axis_tdata,   // draw_handle, overflow, zeros
  output logic [sldo_pkg::LayerW-1:0]     m_axis_tuser,   // layer
  output logic                            m_axis_tlast,
  // configuration write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [sldo_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [sldo_pkg::IdW-1:0]        cfg_data_i
);
  import sldo_pkg::*;

  ctrl_cmd_t          cmd;
  dp_status_t         status;
  logic [HandleW-1:0] out_handle;
  logic               out_overflow;

  // configuration is always taken
  assign cfg_ready_o = 1'b1;

  // controller
  sldo_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_last_i   (s_axis_tlast),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_last_o  (m_axis_tlast),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // datapath
  sldo_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_handle_i    (s_axis_tdata[HandleW-1:0]),
    .in_id_i        (s_axis_tdata[HandleW+IdW-1:HandleW]),
    .in_hidden_i    (s_axis_tuser),
    .in_last_i      (s_axis_tlast),
    .cfg_we_i       (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_handle_o   (out_handle),
    .out_layer_o    (m_axis_tuser),
    .out_overflow_o (out_overflow)
  );

  // pack the result word
  assign m_axis_tdata = {(OutDataW - HandleW - 1)'(0), out_overflow, out_handle};

endmodule
